### hdl/sha256_byte_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// sha256 byte stream hasher assertion macros
// implication checks on the rising clock edge, gated off while in reset
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTH

// same cycle implication
`define SHABS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same cycle check failed");

// next cycle implication
`define SHABS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`else

`define SHABS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SHABS_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### hdl/shabs_pkg.sv
// ----------------------------------------------------------------------------
// shabs_pkg
// shared types and constants of the sha256 byte stream hasher
// ----------------------------------------------------------------------------
package shabs_pkg;

    localparam int unsigned BLOCK_BYTES     = 64;
    localparam int unsigned WIN_W           = BLOCK_BYTES * 8;
    localparam int unsigned POS_W           = 6;
    localparam int unsigned LEN_W           = 64;
    localparam int unsigned BYTE_CNT_W      = LEN_W - 3;
    localparam int unsigned DIGEST_WORDS    = 8;
    localparam int unsigned ROUNDS          = 64;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [POS_W-1:0] LAST_BYTE  = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] LEN_START  = POS_W'(56);
    localparam logic [5:0]       LAST_ROUND = 6'(ROUNDS - 1);
    localparam logic [2:0]       LAST_WORD  = 3'(DIGEST_WORDS - 1);
    localparam logic [7:0]       PAD_MARK   = 8'h80;

    localparam logic [31:0] INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // work classes handed from the front to the back
    typedef enum logic [1:0] {
        CMD_ABSORB       = 2'd0,
        CMD_ABSORB_BLOCK = 2'd1,
        CMD_FINISH_ONE   = 2'd2,
        CMD_FINISH_TWO   = 2'd3
    } t_cmd;

    // arg holds the byte for absorbs, the message bit length for finishes
    typedef struct packed {
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] arg;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hdl/shabs_in_if.sv
// ----------------------------------------------------------------------------
// shabs_in_if
// input channel: one absorb or finish transaction per handshake
// ----------------------------------------------------------------------------
interface shabs_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

### hdl/shabs_out_if.sv
// ----------------------------------------------------------------------------
// shabs_out_if
// output channel: one digest word per handshake
// ----------------------------------------------------------------------------
interface shabs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

### hdl/shabs_front.sv
// ----------------------------------------------------------------------------
// shabs_front
// accepts input transactions, tracks message length, classifies the work
// ----------------------------------------------------------------------------
module shabs_front
    import shabs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    shabs_in_if.sink     i_in,
    input  t_q_stat      i_stat,
    output logic         o_push,
    output t_entry       o_entry
);

    logic [BYTE_CNT_W-1:0] r_byte_cnt;
    logic [BYTE_CNT_W-1:0] n_byte_cnt;
    logic [POS_W-1:0]      pos;

    assign i_in.ready = !i_stat.full;
    assign o_push     = i_in.valid && !i_stat.full;
    assign pos        = r_byte_cnt[POS_W-1:0];

    always_comb begin
        o_entry.pos = pos;
        n_byte_cnt  = r_byte_cnt;
        if (i_in.action) begin
            // bit length mod 2^64 is the byte count shifted by three
            o_entry.arg = {r_byte_cnt, 3'b000};
            o_entry.cmd = (pos >= LEN_START) ? CMD_FINISH_TWO : CMD_FINISH_ONE;
            n_byte_cnt  = '0;
        end else begin
            o_entry.arg = {{(LEN_W-8){1'b0}}, i_in.data_byte};
            o_entry.cmd = (pos == LAST_BYTE) ? CMD_ABSORB_BLOCK : CMD_ABSORB;
            n_byte_cnt  = r_byte_cnt + BYTE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
        end else if (o_push) begin
            r_byte_cnt <= n_byte_cnt;
        end
    end

endmodule

### hdl/shabs_fifo.sv
// ----------------------------------------------------------------------------
// shabs_fifo
// short work queue between the front and the back
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_defines.svh"

module shabs_fifo
    import shabs_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_entry,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;

    assign o_entry      = r_mem[r_rd];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `SHABS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_count != CNT_W'(DEPTH))
    `SHABS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

### hdl/shabs_back.sv
// ----------------------------------------------------------------------------
// shabs_back
// block window, padding sequencer, one-round-per-cycle compression, digest out
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_defines.svh"

module shabs_back
    import shabs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_entry       i_entry,
    input  t_q_stat      i_stat,
    output logic         o_pop,
    shabs_out_if.source  o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    t_state            r_state, n_state;
    logic [WIN_W-1:0]  r_win, n_win;
    logic [31:0]       r_work  [0:7];
    logic [31:0]       n_work  [0:7];
    logic [31:0]       r_chain [0:7];
    logic [31:0]       n_chain [0:7];
    logic [5:0]        r_round, n_round;
    logic [POS_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_two, n_two;
    logic              r_final, n_final;
    logic [2:0]        r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_word, n_out_word;
    logic [2:0]        r_out_index, n_out_index;
    logic              r_out_last, n_out_last;

    logic [7:0]        pad_byte;
    logic [31:0]       big0, big1, choose, major, t1, sched;
    logic [31:0]       w0, w1, w9, w14;

    // message schedule taps, word 0 is the oldest in the window
    assign w0  = r_win[WIN_W-1 -: 32];
    assign w1  = r_win[WIN_W-33 -: 32];
    assign w9  = r_win[WIN_W-1-9*32 -: 32];
    assign w14 = r_win[WIN_W-1-14*32 -: 32];

    assign sched = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    assign big1   = rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25);
    assign choose = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign t1     = r_work[7] + big1 + choose + ROUND_K[r_round] + w0;
    assign big0   = rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22);
    assign major  = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                  ^ (r_work[1] & r_work[2]);

    // zero fill, then the length big-endian in the last eight bytes of the final block
    assign pad_byte = (!r_two && (r_fill >= LEN_START)) ?
                      r_len[{~r_fill[2:0], 3'b000} +: 8] : 8'h00;

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_work      = r_work;
        n_chain     = r_chain;
        n_round     = r_round;
        n_fill      = r_fill;
        n_len       = r_len;
        n_two       = r_two;
        n_final     = r_final;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_word  = r_out_word;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop = 1'b1;
                    unique case (i_entry.cmd)
                        CMD_ABSORB: begin
                            n_win = {r_win[WIN_W-9:0], i_entry.arg[7:0]};
                        end
                        CMD_ABSORB_BLOCK: begin
                            n_win   = {r_win[WIN_W-9:0], i_entry.arg[7:0]};
                            n_work  = r_chain;
                            n_round = '0;
                            n_final = 1'b0;
                            n_state = S_ROUND;
                        end
                        CMD_FINISH_ONE, CMD_FINISH_TWO: begin
                            n_win  = {r_win[WIN_W-9:0], PAD_MARK};
                            n_len  = i_entry.arg;
                            n_fill = i_entry.pos + POS_W'(1);
                            n_two  = (i_entry.cmd == CMD_FINISH_TWO);
                            // marker lands on the last byte: block already full
                            if (i_entry.pos == LAST_BYTE) begin
                                n_work  = r_chain;
                                n_round = '0;
                                n_final = 1'b0;
                                n_state = S_ROUND;
                            end else begin
                                n_state = S_PAD;
                            end
                        end
                    endcase
                end
            end
            S_PAD: begin
                n_win  = {r_win[WIN_W-9:0], pad_byte};
                n_fill = r_fill + POS_W'(1);
                if (r_fill == LAST_BYTE) begin
                    n_work  = r_chain;
                    n_round = '0;
                    n_final = !r_two;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_work[0] = t1 + big0 + major;
                n_work[1] = r_work[0];
                n_work[2] = r_work[1];
                n_work[3] = r_work[2];
                n_work[4] = r_work[3] + t1;
                n_work[5] = r_work[4];
                n_work[6] = r_work[5];
                n_work[7] = r_work[6];
                n_win     = {r_win[WIN_W-33:0], sched};
                n_round   = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_work[i];
                end
                priority if (r_final) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else if (r_two) begin
                    // second padding block of a long tail
                    n_two   = 1'b0;
                    n_fill  = '0;
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_chain[r_idx];
                    n_out_index = r_idx;
                    n_out_last  = (r_idx == LAST_WORD);
                    n_idx       = r_idx + 3'd1;
                    if (r_idx == LAST_WORD) begin
                        n_chain = INIT_HASH;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chain     <= INIT_HASH;
            r_round     <= '0;
            r_fill      <= '0;
            r_two       <= 1'b0;
            r_final     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_round     <= n_round;
            r_fill      <= n_fill;
            r_two       <= n_two;
            r_final     <= n_final;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_work      <= n_work;
        r_len       <= n_len;
        r_out_word  <= n_out_word;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_word = r_out_word;
    assign o_out.word_index  = r_out_index;
    assign o_out.last_word   = r_out_last;

    `SHABS_ASSERT_NXT(a_round_run, i_clk, i_rst_n, r_state == S_ROUND && r_round != LAST_ROUND, r_state == S_ROUND)
    `SHABS_ASSERT_NXT(a_final_emits, i_clk, i_rst_n, r_state == S_FOLD && r_final, r_state == S_EMIT && r_idx == '0)
    `SHABS_ASSERT_IMP(a_out_last, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_index == LAST_WORD)

endmodule

### hdl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream, eight digest words out per finished message
// ----------------------------------------------------------------------------
//
// channel  dir  payload                                  transaction
// -------  ---  ---------------------------------------  -------------------------
// i_in     in   action, data_byte                        one byte or one finish
// o_out    out  digest_word, word_index, last_word       one digest word
//
// - an absorb shifts one byte into the block window in the back; the 64th byte
//   of a block also runs the compression rounds and the fold
// - a finish runs the padding, one or two compressions and the output of the
//   eight digest words; a single round unit serves every compression
// - reset clears control state and loads the initial hash values
// - the front keeps taking transactions into the work queue, until it is full,
//   while the back compresses or while a digest word waits at the output register
//
module sha256_byte_stream_hasher
    import shabs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    shabs_in_if.sink     i_in,
    shabs_out_if.source  o_out
);

    // queue traffic between the front and the back
    logic    push;
    logic    pop;
    t_entry  push_entry;
    t_entry  pop_entry;
    t_q_stat q_stat;

    // front: handshake, length count, classifies block ends and padding size
    shabs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (q_stat),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // work queue lets the front run ahead of a compression
    shabs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_stat  (q_stat)
    );

    // back: block window, padding, rounds and the digest output register
    shabs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (pop_entry),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
